// ===== hw/rtl/terrain_shadow_map_ray_march_macros.svh =====
// assertion macros shared by the ray march block
`ifndef TERRAIN_SHADOW_MAP_RAY_MARCH_MACROS_SVH
`define TERRAIN_SHADOW_MAP_RAY_MARCH_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define TSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define TSM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TSM_ASSERT(label, prop, msg)
`define TSM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/tsm_pkg.sv =====
package tsm_pkg;

   localparam int MAX_MAP_SIZE    = 256;
   localparam int MAX_MARCH_STEPS = 512;
   localparam int MAP_DEPTH       = MAX_MAP_SIZE * MAX_MAP_SIZE;
   localparam int ADDR_W          = $clog2(MAP_DEPTH);
   localparam int COORD_W         = $clog2(MAX_MAP_SIZE);
   localparam int SIZE_W          = COORD_W + 1;
   localparam int STEP_W          = $clog2(MAX_MARCH_STEPS + 1);
   localparam int FRAC            = 12;
   localparam int PX_W            = COORD_W + FRAC + 2;
   localparam int LIGHT_W         = 16;
   localparam int RISE_W          = 18;
   localparam int HEIGHT_W        = 8;
   localparam int FLAG_W          = 18;
   localparam int WGT_W           = 2 * FRAC + 1;
   localparam int RAY_W           = RISE_W + STEP_W + 21;
   localparam int ACC_H_W         = WGT_W + HEIGHT_W;
   localparam int ACC_F_W         = WGT_W + 1 + FLAG_W;
   localparam int CSR_W           = 18;
   localparam int SHADE_W         = 8;

   localparam logic [1:0] REG_MAP_SIZE = 2'd0;
   localparam logic [1:0] REG_LIGHT_DX = 2'd1;
   localparam logic [1:0] REG_LIGHT_DZ = 2'd2;
   localparam logic [1:0] REG_RISE     = 2'd3;

   localparam logic [SHADE_W-1:0] SHADE_DARK = 8'd192;
   localparam logic [SHADE_W-1:0] SHADE_LIT  = 8'd0;

   typedef struct packed {
      logic       load;
      logic       clr_start;
      logic       clr_step;
      logic       pix_start;
      logic       base_load;
      logic       step;
      logic       wgt;
      logic [1:0] rd_sel;
      logic       acc_en;
      logic [1:0] acc_sel;
      logic       cmp;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic pass_start;
      logic clr_done;
      logic leave;
      logic hit;
      logic stop_lit;
   } status_type;

endpackage

// ===== hw/rtl/tsm_ram.sv =====
module tsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tsm_dp.sv =====
module tsm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  tsm_pkg::cmd_type             cmd,
   output tsm_pkg::status_type          status,
   input  logic [7:0]                   req_height_sample,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [tsm_pkg::CSR_W-1:0]    csr_data,
   output logic [7:0]                   rsp_pixel_col,
   output logic [7:0]                   rsp_pixel_row,
   output logic [7:0]                   rsp_shade,
   output logic                         rsp_last_pixel
);
   import tsm_pkg::*;

   localparam logic signed [RAY_W-1:0] FLAG_LO = -(RAY_W'(64'sd6442450944));
   localparam logic signed [RAY_W-1:0] FLAG_HI = -(RAY_W'(64'sd2147483648));
   localparam logic signed [FLAG_W-1:0] FLAG_LIT = -(FLAG_W'(256));
   localparam logic [FLAG_W-2:0] FLAG_SAT = '1;
   localparam logic [FRAC:0] ONE = (FRAC+1)'(1 << FRAC);

   // configuration
   logic [SIZE_W-1:0]         size_ff, size_in;
   logic [COORD_W-1:0]        size_m1_ff, size_m1_in;
   logic [ADDR_W-1:0]         total_m1_ff, total_m1_in;
   logic signed [LIGHT_W-1:0] dx_ff, dx_in, dz_ff, dz_in;
   logic signed [RISE_W-1:0]  rise_ff, rise_in;
   logic [SIZE_W-1:0]         s_raw, s_cl;
   logic [2*SIZE_W-1:0]       s_sq;

   // counters
   logic [ADDR_W-1:0]  load_ff, load_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [COORD_W-1:0] outer_ff, outer_in, inner_ff, inner_in;

   // ray state
   logic signed [PX_W-1:0]  px_ff, px_in, py_ff, py_in, px_nx, py_nx, lim;
   logic signed [RAY_W-1:0] ray_ff, ray_in, ray_nx;
   logic [STEP_W-1:0]       k_ff, k_in;
   logic [WGT_W-1:0]        w_ff [4];
   logic [WGT_W-1:0]        w_in [4];
   logic [ADDR_W-1:0]       i00_ff, i00_in;
   logic [ACC_H_W-1:0]      acc_h_ff, acc_h_in;
   logic signed [ACC_F_W-1:0] acc_f_ff, acc_f_in;
   logic signed [FLAG_W-1:0]  flag_res_ff, flag_res_in;
   logic [SHADE_W-1:0]      shade_res_ff, shade_res_in;

   // result registers
   logic [7:0] col_out_ff, col_out_in, row_out_ff, row_out_in, shade_out_ff, shade_out_in;
   logic       last_out_ff, last_out_in;

   // pixel geometry
   logic [LIGHT_W:0]     adx, adz;
   logic                 xdom;
   logic [COORD_W-1:0]   col_a, row_a, col, row;
   logic [COORD_W+SIZE_W-1:0] idx_w;
   logic [ADDR_W-1:0]    idx;

   // sampling
   logic [FRAC:0]        u1, v1;
   logic [FRAC-1:0]      du, dv;
   logic [2*FRAC+1:0]    p0, p1, p2, p3;
   logic [COORD_W+SIZE_W-1:0] i00_w;
   logic [ADDR_W-1:0]    rd_addr, h_raddr, f_waddr;
   logic                 f_we;
   logic signed [FLAG_W-1:0] f_wdata;
   logic [HEIGHT_W-1:0]  h_rdata;
   logic signed [FLAG_W-1:0] f_rdata;
   logic [WGT_W-1:0]     w_sel;
   logic signed [ACC_F_W-1:0] prod_f;

   // compare
   logic signed [RAY_W-1:0] hv, fv, val, diff, ex;

   // ---------------- configuration ----------------
   always_comb begin
      s_raw = csr_data[SIZE_W-1:0];
      if (s_raw < SIZE_W'(4)) begin
         s_cl = SIZE_W'(4);
      end else if (s_raw > SIZE_W'(MAX_MAP_SIZE)) begin
         s_cl = SIZE_W'(MAX_MAP_SIZE);
      end else begin
         s_cl = s_raw;
      end
      s_sq = s_cl * s_cl;
   end

   always_comb begin
      size_in     = size_ff;
      size_m1_in  = size_m1_ff;
      total_m1_in = total_m1_ff;
      dx_in       = dx_ff;
      dz_in       = dz_ff;
      rise_in     = rise_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAP_SIZE: begin
               size_in     = s_cl;
               size_m1_in  = COORD_W'(s_cl - SIZE_W'(1));
               total_m1_in = ADDR_W'(s_sq - (2*SIZE_W)'(1));
            end
            REG_LIGHT_DX: dx_in = csr_data[LIGHT_W-1:0];
            REG_LIGHT_DZ: dz_in = csr_data[LIGHT_W-1:0];
            REG_RISE:     rise_in = csr_data[RISE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_W'(MAX_MAP_SIZE);
         size_m1_ff  <= COORD_W'(MAX_MAP_SIZE - 1);
         total_m1_ff <= ADDR_W'(MAP_DEPTH - 1);
         dx_ff       <= LIGHT_W'(2048);
         dz_ff       <= LIGHT_W'(2867);
         rise_ff     <= RISE_W'(4096);
      end else begin
         size_ff     <= size_in;
         size_m1_ff  <= size_m1_in;
         total_m1_ff <= total_m1_in;
         dx_ff       <= dx_in;
         dz_ff       <= dz_in;
         rise_ff     <= rise_in;
      end
   end

   // ---------------- pixel order ----------------
   always_comb begin
      adx   = dx_ff[LIGHT_W-1] ? -{dx_ff[LIGHT_W-1], dx_ff} : {1'b0, dx_ff};
      adz   = dz_ff[LIGHT_W-1] ? -{dz_ff[LIGHT_W-1], dz_ff} : {1'b0, dz_ff};
      xdom  = adx > adz;
      col_a = xdom ? outer_ff : inner_ff;
      row_a = xdom ? inner_ff : outer_ff;
      col   = dx_ff[LIGHT_W-1] ? size_m1_ff - col_a : col_a;
      row   = dz_ff[LIGHT_W-1] ? size_m1_ff - row_a : row_a;
      idx_w = row * size_ff + (COORD_W+SIZE_W)'(col);
      idx   = idx_w[ADDR_W-1:0];
   end

   // ---------------- counters ----------------
   always_comb begin
      load_in  = load_ff;
      clr_in   = clr_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (cmd.load) begin
         load_in = (load_ff == total_m1_ff) ? '0 : load_ff + ADDR_W'(1);
      end
      if (cmd.clr_start) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.fin) begin
         if (inner_ff == size_m1_ff) begin
            inner_in = '0;
            outer_in = (outer_ff == size_m1_ff) ? '0 : outer_ff + COORD_W'(1);
         end else begin
            inner_in = inner_ff + COORD_W'(1);
         end
      end
      // any register write restarts the pass, the size also restarts loading
      if (csr_we) begin
         outer_in = '0;
         inner_in = '0;
         if (csr_index == REG_MAP_SIZE) begin
            load_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= '0;
         clr_ff   <= '0;
         outer_ff <= '0;
         inner_ff <= '0;
      end else begin
         load_ff  <= load_in;
         clr_ff   <= clr_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
      end
   end

   // ---------------- march ----------------
   always_comb begin
      lim    = PX_W'({size_m1_ff, {FRAC{1'b0}}});
      px_nx  = px_ff - PX_W'(dx_ff);
      py_nx  = py_ff - PX_W'(dz_ff);
      ray_nx = ray_ff + (RAY_W'(rise_ff) <<< 20);
      du     = px_ff[FRAC-1:0];
      dv     = py_ff[FRAC-1:0];
      u1     = ONE - (FRAC+1)'(du);
      v1     = ONE - (FRAC+1)'(dv);
      p0     = u1 * v1;
      p1     = u1 * (FRAC+1)'(dv);
      p2     = (FRAC+1)'(du) * v1;
      p3     = (FRAC+1)'(du) * (FRAC+1)'(dv);
      i00_w  = py_ff[FRAC+COORD_W-1:FRAC] * size_ff
               + (COORD_W+SIZE_W)'(px_ff[FRAC+COORD_W-1:FRAC]);
   end

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_addr = i00_ff;
         2'd1:    rd_addr = i00_ff + ADDR_W'(size_ff);
         2'd2:    rd_addr = i00_ff + ADDR_W'(1);
         default: rd_addr = i00_ff + ADDR_W'(size_ff) + ADDR_W'(1);
      endcase
      w_sel  = w_ff[cmd.acc_sel];
      prod_f = ACC_F_W'($signed({1'b0, w_sel}) * f_rdata);
   end

   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      ray_in       = ray_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      i00_in       = i00_ff;
      acc_h_in     = acc_h_ff;
      acc_f_in     = acc_f_ff;
      flag_res_in  = flag_res_ff;
      shade_res_in = shade_res_ff;
      if (cmd.base_load) begin
         px_in        = PX_W'({col, {FRAC{1'b0}}});
         py_in        = PX_W'({row, {FRAC{1'b0}}});
         ray_in       = RAY_W'({h_rdata, 32'b0});
         k_in         = '0;
         flag_res_in  = FLAG_LIT;
         shade_res_in = SHADE_LIT;
      end
      if (cmd.step) begin
         px_in  = px_nx;
         py_in  = py_nx;
         ray_in = ray_nx;
         k_in   = k_ff + STEP_W'(1);
      end
      if (cmd.wgt) begin
         w_in[0]  = p0[WGT_W-1:0];
         w_in[1]  = p1[WGT_W-1:0];
         w_in[2]  = p2[WGT_W-1:0];
         w_in[3]  = p3[WGT_W-1:0];
         i00_in   = i00_w[ADDR_W-1:0];
         acc_h_in = '0;
         acc_f_in = '0;
      end
      if (cmd.acc_en) begin
         acc_h_in = acc_h_ff + ACC_H_W'(w_sel * h_rdata);
         acc_f_in = acc_f_ff + prod_f;
      end
      if (cmd.cmp && status.hit) begin
         flag_res_in  = (ex > RAY_W'(FLAG_SAT)) ? FLAG_W'({1'b0, FLAG_SAT})
                                                : ex[FLAG_W-1:0];
         shade_res_in = SHADE_DARK;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      ray_ff       <= ray_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      i00_ff       <= i00_in;
      acc_h_ff     <= acc_h_in;
      acc_f_ff     <= acc_f_in;
      flag_res_ff  <= flag_res_in;
      shade_res_ff <= shade_res_in;
   end

   // heights at 32 fraction bits against the flag sum and the ray
   always_comb begin
      hv   = RAY_W'({acc_h_ff, 8'b0});
      fv   = RAY_W'(acc_f_ff);
      val  = (hv < fv) ? fv : hv;
      diff = val - ray_ff;
      ex   = diff >>> 24;
   end

   always_comb begin
      status.pass_start = (outer_ff == '0) && (inner_ff == '0);
      status.clr_done   = clr_ff == total_m1_ff;
      status.leave      = (k_ff == STEP_W'(MAX_MARCH_STEPS)) || (px_nx < 0) || (px_nx >= lim)
                          || (py_nx < 0) || (py_nx >= lim);
      status.hit        = ray_ff < val;
      status.stop_lit   = (fv > FLAG_LO) && (fv < FLAG_HI);
   end

   // ---------------- stores ----------------
   assign h_raddr = cmd.pix_start ? idx : rd_addr;
   assign f_we    = cmd.clr_step || cmd.fin;
   assign f_waddr = cmd.fin ? idx : clr_ff;
   assign f_wdata = cmd.fin ? flag_res_ff : '0;

   tsm_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_DEPTH)) u_height (
      .clock (clock),
      .we    (cmd.load),
      .waddr (load_ff),
      .wdata (req_height_sample),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   tsm_ram #(.WIDTH(FLAG_W), .DEPTH(MAP_DEPTH)) u_flag (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (rd_addr),
      .rdata (f_rdata)
   );

   // ---------------- result ----------------
   always_comb begin
      col_out_in   = col_out_ff;
      row_out_in   = row_out_ff;
      shade_out_in = shade_out_ff;
      last_out_in  = last_out_ff;
      if (cmd.fin) begin
         col_out_in   = 8'(col);
         row_out_in   = 8'(row);
         shade_out_in = shade_res_ff;
         last_out_in  = (outer_ff == size_m1_ff) && (inner_ff == size_m1_ff);
      end
   end

   always_ff @(posedge clock) begin
      col_out_ff   <= col_out_in;
      row_out_ff   <= row_out_in;
      shade_out_ff <= shade_out_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_pixel_col  = col_out_ff;
   assign rsp_pixel_row  = row_out_ff;
   assign rsp_shade      = shade_out_ff;
   assign rsp_last_pixel = last_out_ff;

endmodule

// ===== hw/rtl/tsm_ctrl.sv =====
`include "terrain_shadow_map_ray_march_macros.svh"

module tsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tsm_pkg::status_type status,
   output tsm_pkg::cmd_type    cmd
);
   import tsm_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_BASE  = 4'd3;
   localparam logic [3:0] S_STEP  = 4'd4;
   localparam logic [3:0] S_WGT   = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_CMP   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   localparam logic [2:0] LAST_PHASE = 3'd4;

   logic [3:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_mode) begin
                  cmd.load = 1'b1;
               end else if (status.pass_start) begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLEAR;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.pix_start = 1'b1;
            state_in      = S_BASE;
         end
         S_BASE: begin
            cmd.base_load = 1'b1;
            state_in      = S_STEP;
         end
         S_STEP: begin
            if (status.leave) begin
               state_in = S_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = S_WGT;
            end
         end
         S_WGT: begin
            cmd.wgt  = 1'b1;
            phase_in = '0;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.rd_sel = phase_ff[1:0];
            if (phase_ff != '0) begin
               cmd.acc_en  = 1'b1;
               cmd.acc_sel = 2'(phase_ff - 3'd1);
            end
            phase_in = phase_ff + 3'd1;
            if (phase_ff == LAST_PHASE) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            if (status.hit || status.stop_lit) begin
               state_in = S_FIN;
            end else begin
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `TSM_ASSERT(a_fin_shows_beat, (state_ff == S_FIN && !rsp_valid_ff) |=> rsp_valid_ff, "finished pixel not shown")
   `TSM_ASSERT(a_clear_to_start, (state_ff == S_CLEAR && status.clr_done) |=> state_ff == S_START, "clear pass did not end")
   `TSM_ASSERT(a_hit_finishes, (state_ff == S_CMP && status.hit) |=> state_ff == S_FIN, "hit did not end the march")
   `TSM_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (state_ff == S_IDLE && !rsp_valid_ff), "reset left block busy")

endmodule

// ===== hw/rtl/terrain_shadow_map_ray_march.sv =====
// load beat: taken in the idle state, a new beat may follow in the next cycle
// shade beat: a loop of march steps that ends when the ray leaves the map or reaches the 512 step cap,
//    or when it stops on terrain or a flag; each step passes the step state, the weight state,
//    reads of the four corners of both stores one after another and the compare state
// first pixel of a pass adds a clear of all map_size squared flag store entries
// synchronous active-high reset: idle, no result pending, registers at reset values
module terrain_shadow_map_ray_march (
   input  logic                      clock,
   input  logic                      reset,
   // input beats
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [7:0]                req_height_sample,
   // result beats
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_pixel_col,
   output logic [7:0]                rsp_pixel_row,
   output logic [7:0]                rsp_shade,
   output logic                      rsp_last_pixel,
   // register writes
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [tsm_pkg::CSR_W-1:0] csr_data
);
   import tsm_pkg::*;

   // commands from the sequencer, status back from the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: load, clear sweep, per-step march loop, result hand-off
   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, pixel order, ray position, bilinear sums, stores
   tsm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_height_sample (req_height_sample),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_pixel_col     (rsp_pixel_col),
      .rsp_pixel_row     (rsp_pixel_row),
      .rsp_shade         (rsp_shade),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

// ===== tb/tsm_shade_checker.sv =====
module tsm_shade_checker
   import tsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_mode,
   input  logic [7:0]        req_height_sample,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_pixel_col,
   input  logic [7:0]        rsp_pixel_row,
   input  logic [7:0]        rsp_shade,
   input  logic              rsp_last_pixel,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   output int                fail_count,
   output int                pending
);

   localparam longint ONE12 = 64'sd4096;
   localparam longint ONE24 = 64'sd16777216;
   localparam longint ONE36 = 64'sd68719476736;
   localparam int FLAG_LIT_VAL = -256;
   localparam int FLAG_SAT = 131071;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] shade;
      logic       last;
   } pixel_type;

   pixel_type  pixel_q[$];
   logic [7:0] heights [MAP_DEPTH];
   int         flags [MAP_DEPTH];
   int         load_idx;
   int         pix_idx;
   int         side;
   longint     dx;
   longint     dz;
   longint     rise;

   // march one pixel against the light and update the flag store
   function automatic pixel_type shade_pixel();
      int total, outer, inner, col, row, idx, x0, y0, i00, i10, flag;
      longint px, py, lim, base, du, dv, w0, w1, w2, w3, ih, ifl, ray, val, ex;
      logic [7:0] sh;
      pixel_type r;
      total = side * side;
      if (pix_idx >= total) pix_idx = 0;
      if (pix_idx == 0) for (int i = 0; i < total; i++) flags[i] = 0;
      outer = pix_idx / side;
      inner = pix_idx % side;
      if ((dx < 0 ? -dx : dx) > (dz < 0 ? -dz : dz)) begin
         col = (dx < 0) ? side - 1 - outer : outer;
         row = (dz < 0) ? side - 1 - inner : inner;
      end else begin
         row = (dz < 0) ? side - 1 - outer : outer;
         col = (dx < 0) ? side - 1 - inner : inner;
      end
      idx  = row * side + col;
      px   = longint'(col) * ONE12;
      py   = longint'(row) * ONE12;
      lim  = longint'(side - 1) * ONE12;
      base = longint'(heights[idx]) * ONE36;
      sh   = SHADE_LIT;
      flag = FLAG_LIT_VAL;
      for (int k = 1; k <= MAX_MARCH_STEPS; k++) begin
         px = px - dx;
         py = py - dz;
         if (px < 0 || px >= lim || py < 0 || py >= lim) break;
         x0  = int'(px / ONE12);
         y0  = int'(py / ONE12);
         du  = px - longint'(x0) * ONE12;
         dv  = py - longint'(y0) * ONE12;
         w0  = (ONE12 - du) * (ONE12 - dv);
         w1  = (ONE12 - du) * dv;
         w2  = du * (ONE12 - dv);
         w3  = du * dv;
         i00 = y0 * side + x0;
         i10 = i00 + side;
         ih  = (w0 * heights[i00] + w1 * heights[i10] + w2 * heights[i00 + 1]
                + w3 * heights[i10 + 1]) * ONE12;
         ifl = (w0 * flags[i00] + w1 * flags[i10] + w2 * flags[i00 + 1]
                + w3 * flags[i10 + 1]) * 16;
         ray = base + rise * longint'(k) * ONE24;
         val = (ih < ifl) ? ifl : ih;
         if (ray < val) begin
            ex = (val - ray) / (ONE36 / 256);
            if (ex > FLAG_SAT) ex = FLAG_SAT;
            flag = int'(ex);
            sh = SHADE_DARK;
            break;
         end
         // flag close to -1 means the ray already passed a lit pixel
         if (ifl > -(ONE36 + ONE36 / 2) && ifl < -(ONE36 / 2)) break;
      end
      flags[idx] = flag;
      r.col   = col[7:0];
      r.row   = row[7:0];
      r.shade = sh;
      r.last  = (pix_idx == total - 1);
      pix_idx++;
      if (pix_idx >= total) pix_idx = 0;
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_type got, want;
      int s;
      if (reset) begin
         pixel_q.delete();
         fail_count <= 0;
         load_idx = 0;
         pix_idx  = 0;
         side     = MAX_MAP_SIZE;
         dx       = 2048;
         dz       = 2867;
         rise     = 4096;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pixel_col, rsp_pixel_row, rsp_shade, rsp_last_pixel};
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected result beat col %0d row %0d", $time,
                        rsp_pixel_col, rsp_pixel_row);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (got != want) begin
                  $display("%0t: expected col %0d row %0d shade %0d last %0d, %s",
                           $time, want.col, want.row, want.shade, want.last,
                           $sformatf("got col %0d row %0d shade %0d last %0d",
                                     got.col, got.row, got.shade, got.last));
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            pix_idx = 0;
            case (csr_index)
               REG_MAP_SIZE: begin
                  s = int'(csr_data[8:0]);
                  if (s < 4) s = 4;
                  if (s > MAX_MAP_SIZE) s = MAX_MAP_SIZE;
                  side = s;
                  load_idx = 0;
               end
               REG_LIGHT_DX: dx = longint'($signed(csr_data[15:0]));
               REG_LIGHT_DZ: dz = longint'($signed(csr_data[15:0]));
               REG_RISE:     rise = longint'($signed(csr_data[17:0]));
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_mode == 1'b0) begin
               if (load_idx >= side * side) load_idx = 0;
               heights[load_idx] = req_height_sample;
               load_idx++;
               if (load_idx >= side * side) load_idx = 0;
            end else begin
               pixel_q.push_back(shade_pixel());
            end
         end
      end
      pending <= pixel_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import tsm_pkg::*;

   // cycles with no beat at all before the run is declared hung
   // (covers a full-size flag clear plus a capped march and a stalled receiver)
   localparam int WATCHDOG_LIMIT = 300000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = 1'b0;
   logic [7:0]       req_height_sample = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_pixel_col;
   logic [7:0]       rsp_pixel_row;
   logic [7:0]       rsp_shade;
   logic             rsp_last_pixel;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   int fail_count;
   int pending;
   int send_idle = 34;   // percent of cycles the sender holds back
   int recv_idle = 53;   // percent of cycles the receiver stalls
   int beats_sent = 0;
   int side_now = MAX_MAP_SIZE;
   int stall_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   terrain_shadow_map_ray_march u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_height_sample,
      .rsp_valid, .rsp_ready, .rsp_pixel_col, .rsp_pixel_row, .rsp_shade,
      .rsp_last_pixel,
      .csr_we, .csr_index, .csr_data
   );

   tsm_shade_checker u_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_height_sample,
      .rsp_valid, .rsp_ready, .rsp_pixel_col, .rsp_pixel_row, .rsp_shade,
      .rsp_last_pixel,
      .csr_we, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // receiver back-pressure, one decision per edge
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // hang detection: any accepted beat or register write resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one input beat; valid is only lowered when the sender actually idles
   task automatic send_beat(input logic mode, input logic [7:0] sample);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_height_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      // idle profile follows progress through the random part
      if (beats_sent == 550) begin
         send_idle = 53;
         recv_idle = 34;
      end else if (beats_sent == 1100) begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   // hold off until every pixel is back, then let a trailing load settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_height();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [15:0] pick_light();
      int mag;
      case ($urandom_range(7))
         0: return 16'($urandom_range(65535));
         1: return 16'd0;
         default: begin
            mag = $urandom_range(200, 6000);
            return $urandom_range(1) ? 16'(-mag) : 16'(mag);
         end
      endcase
   endfunction

   function automatic logic [17:0] pick_rise();
      int mag;
      if ($urandom_range(5) == 0) return 18'($urandom_range(262143));
      mag = $urandom_range(0, 6000);
      return $urandom_range(1) ? 18'(-mag) : 18'(mag);
   endfunction

   // one setting: write all registers, load the whole map, then shade the given number of pixels
   task automatic run_setting(input logic [8:0] size_raw, input logic [15:0] dx,
                              input logic [15:0] dz, input logic [17:0] rise,
                              input int shades, input bit noisy);
      int total;
      drain();
      write_reg(REG_MAP_SIZE, {9'($urandom_range(511)), size_raw});
      write_reg(REG_LIGHT_DX, {2'($urandom_range(3)), dx});
      write_reg(REG_LIGHT_DZ, {2'($urandom_range(3)), dz});
      write_reg(REG_RISE, rise);
      side_now = (size_raw < 4) ? 4 : (size_raw > MAX_MAP_SIZE) ? MAX_MAP_SIZE : size_raw;
      total = side_now * side_now;
      for (int i = 0; i < total; i++) send_beat(1'b0, pick_height());
      for (int i = 0; i < shades; i++) begin
         // stray loads in the middle of a pass overwrite heights already in use
         if (noisy && $urandom_range(9) == 0) send_beat(1'b0, pick_height());
         send_beat(1'b1, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      int sz;
      int total;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: smallest map via a clamped size, extreme light and rise,
      // pass wrap and last pixel
      run_setting(9'd0, 16'h8000, 16'h7fff, 18'h20000, 20, 1'b0);
      // axis tie with both components negative, steepest rise
      run_setting(9'd3, 16'(-3000), 16'(-3000), 18'h1ffff, 16, 1'b0);
      // zero light hits the step cap, save on the last row and column, where the ray leaves at once
      run_setting(9'd4, 16'd0, 16'd0, 18'd0, 4, 1'b0);
      // zero z component counts as positive, shallow descending ray
      run_setting(9'd5, 16'd4096, 16'd0, 18'(-100), 25, 1'b0);

      // random settings, mostly small maps
      while (beats_sent < 1600) begin
         sz = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(4, 12);
         total = sz * sz;
         run_setting(9'(sz), pick_light(), pick_light(), pick_rise(),
                     total + $urandom_range(0, total / 2), 1'b1);
      end

      // largest map through a clamped size write: only the start of the first row is loaded
      // and shaded, the light comes from that row's side so every ray leaves at once
      drain();
      write_reg(REG_MAP_SIZE, 18'd511);
      write_reg(REG_LIGHT_DX, 18'd1500);
      write_reg(REG_LIGHT_DZ, 18'd2500);
      write_reg(REG_RISE, 18'd2000);
      for (int i = 0; i < 12; i++) send_beat(1'b0, pick_height());
      for (int i = 0; i < 12; i++) send_beat(1'b1, 8'($urandom_range(255)));

      drain();
      repeat (4000) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_ram.sv
hw/rtl/tsm_dp.sv
hw/rtl/tsm_ctrl.sv
hw/rtl/terrain_shadow_map_ray_march.sv
tb/tsm_shade_checker.sv
tb/testbench.sv
